@@ rtl/alt_pkg.sv @@
// ----------------------------------------------------------------------------
// alt_pkg
// Shared types and constants of the assembly line tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package alt_pkg;

    localparam int LINE_LENGTH_DEF = 1024;
    localparam int FIFO_DEPTH_DEF  = 4;

    localparam int START_W  = 10;
    localparam int LENGTH_W = 11;
    localparam int TYPE_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int DIGIT_W  = 6;

    // digit value of a byte that is no digit in any base
    localparam logic [DIGIT_W-1:0] DIGIT_BAD = '1;

    typedef enum logic [2:0] {
        TT_KEYWORD  = 3'd0,
        TT_REGISTER = 3'd1,
        TT_NUMBER   = 3'd2,
        TT_STRING   = 3'd3,
        TT_PSEUDO   = 3'd4
    } token_type_t;

    // what a first byte means for the number parser
    typedef enum logic [2:0] {
        PFX_NONE,
        PFX_HASH,
        PFX_HEX,
        PFX_BIN,
        PFX_DIGIT
    } prefix_t;

    typedef enum logic [1:0] {
        BASE_2,
        BASE_10,
        BASE_16
    } base_t;

    // one classified byte, as it travels from front to back
    typedef struct packed {
        logic               sep;
        logic               quote;
        logic               bslash;
        logic               dot;
        logic               r_letter;
        logic               reg_digit;
        logic               minus;
        prefix_t            prefix;
        logic [DIGIT_W-1:0] digit;
        logic               eol;
    } class_word_t;

endpackage

`default_nettype wire

@@ rtl/assembly_line_tokenizer_unit.sv @@
// ----------------------------------------------------------------------------
// assembly_line_tokenizer_unit
// Lexer for assembly source lines, one byte per word.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall, carrying character and end_of_line.
// A word is taken on a clock edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall, carrying token_start,
// token_length, token_type and number_value. At most one token per input
// word; it appears when the token closes (separator, closing quote or the
// last byte of a line).
// Throughput: one byte per cycle, sustained while no result is held. The front
// classifies the byte and writes the queue; the back runs the token state and
// its digit multiply-add combinationally and loads the output register.
// Path: a token closed by byte N is written to the queue, then taken by the
// back and loaded into the output register, from which it is accepted.
// Stall: a held result stays in the output register and the back takes no
// further word until it is accepted; the queue then fills (FIFO_DEPTH
// words) until in_stall rises.
// Reset: queue empty, no token open, line position 0, no result pending.
// ----------------------------------------------------------------------------
`default_nettype none

module assembly_line_tokenizer_unit #(
    parameter int LINE_LENGTH = alt_pkg::LINE_LENGTH_DEF,
    parameter int FIFO_DEPTH  = alt_pkg::FIFO_DEPTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [7:0]                    character,
    input  wire logic                          end_of_line,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [alt_pkg::START_W-1:0]        token_start,
    output logic [alt_pkg::LENGTH_W-1:0]       token_length,
    output logic [alt_pkg::TYPE_W-1:0]         token_type,
    output logic signed [alt_pkg::VALUE_W-1:0] number_value
);
    import alt_pkg::*;

    class_word_t front_word;
    class_word_t head_word;
    logic        push;
    logic        fifo_full;
    logic        fifo_not_empty;
    logic        pop;

    alt_front u_front (
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .character   (character),
        .end_of_line (end_of_line),
        .fifo_full   (fifo_full),
        .push        (push),
        .word        (front_word)
    );

    alt_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (front_word),
        .full      (fifo_full),
        .pop       (pop),
        .not_empty (fifo_not_empty),
        .head_word (head_word)
    );

    alt_back #(
        .LINE_LENGTH (LINE_LENGTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .word_valid   (fifo_not_empty),
        .word         (head_word),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .token_start  (token_start),
        .token_length (token_length),
        .token_type   (token_type),
        .number_value (number_value)
    );

endmodule

`default_nettype wire

@@ rtl/alt_front.sv @@
// ----------------------------------------------------------------------------
// alt_front
// Input side: takes a byte, classifies it and pushes it into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module alt_front (
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [7:0]        character,
    input  wire logic              end_of_line,
    input  wire logic              fifo_full,
    output logic                   push,
    output alt_pkg::class_word_t   word
);
    import alt_pkg::*;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_7      = 8'h37;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UB     = 8'h42;
    localparam logic [7:0] CH_UR     = 8'h52;
    localparam logic [7:0] CH_UX     = 8'h58;
    localparam logic [7:0] CH_UZ     = 8'h5A;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LB     = 8'h62;
    localparam logic [7:0] CH_LR     = 8'h72;
    localparam logic [7:0] CH_LX     = 8'h78;
    localparam logic [7:0] CH_LZ     = 8'h7A;
    localparam logic [7:0] ALPHA_OFS = 8'd10;

    logic       is_dec;
    logic [7:0] dv_full;

    assign in_stall = fifo_full;
    assign push     = in_valid && !fifo_full;

    always_comb
    begin
        is_dec = (character >= CH_0) && (character <= CH_9);

        if (is_dec)
        begin
            dv_full = character - CH_0;
        end
        else if ((character >= CH_UA) && (character <= CH_UZ))
        begin
            dv_full = character - CH_UA + ALPHA_OFS;
        end
        else if ((character >= CH_LA) && (character <= CH_LZ))
        begin
            dv_full = character - CH_LA + ALPHA_OFS;
        end
        else
        begin
            dv_full = 8'(DIGIT_BAD);
        end

        word.sep = (character == CH_NUL) || (character == CH_TAB) ||
                   (character == CH_LF) || (character == CH_SPACE) ||
                   (character == CH_COMMA) || (character == CH_COLON) ||
                   (character == CH_SEMI);
        word.quote     = (character == CH_QUOTE);
        word.bslash    = (character == CH_BSLASH);
        word.dot       = (character == CH_DOT);
        word.r_letter  = (character == CH_UR) || (character == CH_LR);
        word.reg_digit = (character >= CH_0) && (character <= CH_7);
        word.minus     = (character == CH_MINUS);
        word.digit     = dv_full[DIGIT_W-1:0];
        word.eol       = end_of_line;

        if (character == CH_HASH)
        begin
            word.prefix = PFX_HASH;
        end
        else if ((character == CH_UX) || (character == CH_LX))
        begin
            word.prefix = PFX_HEX;
        end
        else if ((character == CH_UB) || (character == CH_LB))
        begin
            word.prefix = PFX_BIN;
        end
        else if (is_dec)
        begin
            word.prefix = PFX_DIGIT;
        end
        else
        begin
            word.prefix = PFX_NONE;
        end
    end

endmodule

`default_nettype wire

@@ rtl/alt_fifo.sv @@
// ----------------------------------------------------------------------------
// alt_fifo
// Short queue of classified words between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module alt_fifo #(
    parameter int DEPTH = alt_pkg::FIFO_DEPTH_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire alt_pkg::class_word_t push_word,
    output logic                      full,
    input  wire logic                 pop,
    output logic                      not_empty,
    output alt_pkg::class_word_t      head_word
);
    import alt_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    class_word_t        mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_word = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

`default_nettype wire

@@ rtl/alt_back.sv @@
// ----------------------------------------------------------------------------
// alt_back
// Token state machine: one classified word per cycle while no result is held,
// results into an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module alt_back #(
    parameter int LINE_LENGTH = alt_pkg::LINE_LENGTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          word_valid,
    input  wire alt_pkg::class_word_t          word,
    output logic                               pop,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [alt_pkg::START_W-1:0]        token_start,
    output logic [alt_pkg::LENGTH_W-1:0]       token_length,
    output logic [alt_pkg::TYPE_W-1:0]         token_type,
    output logic signed [alt_pkg::VALUE_W-1:0] number_value
);
    import alt_pkg::*;

    localparam int POS_W = $clog2(LINE_LENGTH);
    localparam int LEN_W = $clog2(LINE_LENGTH + 1);
    localparam int SW    = (POS_W > START_W) ? POS_W : START_W;
    localparam int LW    = (LEN_W > LENGTH_W) ? LEN_W : LENGTH_W;

    // line and token state
    logic [POS_W-1:0]   pos_reg,     pos_next;
    logic               in_tok_reg,  in_tok_next;
    logic               in_str_reg,  in_str_next;
    logic [POS_W-1:0]   start_reg,   start_next;
    logic [LEN_W-1:0]   len_reg,     len_next;
    logic               prev_bs_reg, prev_bs_next;
    logic               fb_dot_reg,  fb_dot_next;
    logic               fb_quote_reg, fb_quote_next;
    logic               fb_r_reg,    fb_r_next;
    logic               sb_reg_reg,  sb_reg_next;
    // number parser state
    base_t              base_reg,    base_next;
    logic               stage_reg,   stage_next;
    logic               neg_reg,     neg_next;
    logic               ok_reg,      ok_next;
    logic               dseen_reg,   dseen_next;
    logic [VALUE_W-1:0] acc_reg,     acc_next;
    // output register
    logic                out_valid_reg, out_valid_next;
    logic [START_W-1:0]  out_start_reg, out_start_next;
    logic [LENGTH_W-1:0] out_len_reg,   out_len_next;
    token_type_t         out_type_reg,  out_type_next;
    logic [VALUE_W-1:0]  out_value_reg, out_value_next;

    logic               take;
    logic               emit;
    logic               take_digit;
    logic [4:0]         base_val;
    logic [VALUE_W-1:0] scaled;
    logic [VALUE_W-1:0] term;
    logic [SW-1:0]      start_wide;
    logic [LW-1:0]      len_wide;

    assign take = word_valid && (!out_valid_reg || !out_stall);
    assign pop  = take;

    assign out_valid    = out_valid_reg;
    assign token_start  = out_start_reg;
    assign token_length = out_len_reg;
    assign token_type   = TYPE_W'(out_type_reg);
    assign number_value = out_value_reg;

    // multiply-add for the digit step; bases are 2, 10 and 16
    always_comb
    begin
        case (base_reg)
            BASE_2:  base_val = 5'd2;
            BASE_10: base_val = 5'd10;
            BASE_16: base_val = 5'd16;
            default: base_val = 5'd10;
        endcase

        case (base_reg)
            BASE_2:  scaled = {acc_reg[VALUE_W-2:0], 1'b0};
            BASE_16: scaled = {acc_reg[VALUE_W-5:0], 4'b0};
            BASE_10: scaled = {acc_reg[VALUE_W-4:0], 3'b0} + {acc_reg[VALUE_W-2:0], 1'b0};
            default: scaled = acc_reg;
        endcase

        // value is kept signed, so a minus subtracts each digit
        term = neg_reg ? (VALUE_W'(0) - VALUE_W'(word.digit)) : VALUE_W'(word.digit);
    end

    always_comb
    begin
        pos_next      = pos_reg;
        in_tok_next   = in_tok_reg;
        in_str_next   = in_str_reg;
        start_next    = start_reg;
        len_next      = len_reg;
        prev_bs_next  = prev_bs_reg;
        fb_dot_next   = fb_dot_reg;
        fb_quote_next = fb_quote_reg;
        fb_r_next     = fb_r_reg;
        sb_reg_next   = sb_reg_reg;
        base_next     = base_reg;
        stage_next    = stage_reg;
        neg_next      = neg_reg;
        ok_next       = ok_reg;
        dseen_next    = dseen_reg;
        acc_next      = acc_reg;
        emit          = 1'b0;
        take_digit    = 1'b0;

        if (!in_tok_reg)
        begin
            if (!word.sep)
            begin
                in_tok_next   = 1'b1;
                in_str_next   = word.quote;
                start_next    = pos_reg;
                len_next      = LEN_W'(1);
                fb_dot_next   = word.dot;
                fb_quote_next = word.quote;
                fb_r_next     = word.r_letter;
                sb_reg_next   = 1'b0;
                prev_bs_next  = word.bslash;
                neg_next      = 1'b0;
                dseen_next    = 1'b0;
                acc_next      = '0;
                ok_next       = 1'b1;
                stage_next    = 1'b0;
                base_next     = BASE_10;
                case (word.prefix)
                    PFX_HASH:  base_next = BASE_10;
                    PFX_HEX:   base_next = BASE_16;
                    PFX_BIN:   base_next = BASE_2;
                    PFX_DIGIT:
                    begin
                        // a leading decimal digit is always valid
                        stage_next = 1'b1;
                        dseen_next = 1'b1;
                        acc_next   = VALUE_W'(word.digit);
                    end
                    default:   ok_next = 1'b0;
                endcase
            end
        end
        else if (in_str_reg)
        begin
            if (len_reg < LEN_W'(LINE_LENGTH))
            begin
                len_next = len_reg + 1'b1;
            end
            if (len_next == LEN_W'(2))
            begin
                sb_reg_next = word.reg_digit;
            end
            if (word.quote && !prev_bs_reg)
            begin
                emit = 1'b1;
            end
            else
            begin
                prev_bs_next = word.bslash;
            end
        end
        else if (word.sep)
        begin
            emit = 1'b1;
        end
        else
        begin
            if (len_reg < LEN_W'(LINE_LENGTH))
            begin
                len_next = len_reg + 1'b1;
            end
            if (len_next == LEN_W'(2))
            begin
                sb_reg_next = word.reg_digit;
            end
            prev_bs_next = word.bslash;
            if (ok_reg)
            begin
                if (!stage_reg)
                begin
                    stage_next = 1'b1;
                    if (word.minus)
                    begin
                        neg_next = 1'b1;
                    end
                    else
                    begin
                        take_digit = 1'b1;
                    end
                end
                else
                begin
                    take_digit = 1'b1;
                end
            end
            if (take_digit)
            begin
                if (word.digit >= {1'b0, base_val})
                begin
                    ok_next = 1'b0;
                end
                else
                begin
                    acc_next   = scaled + term;
                    dseen_next = 1'b1;
                end
            end
        end

        if (word.eol)
        begin
            if (in_tok_next && !emit)
            begin
                emit = 1'b1;
            end
            pos_next = '0;
        end
        else if (pos_reg < POS_W'(LINE_LENGTH - 1))
        begin
            pos_next = pos_reg + 1'b1;
        end

        if (emit)
        begin
            in_tok_next = 1'b0;
            in_str_next = 1'b0;
        end
        if (word.eol)
        begin
            in_tok_next = 1'b0;
            in_str_next = 1'b0;
        end
    end

    // token fields from the updated token state
    always_comb
    begin
        start_wide     = SW'(start_next);
        len_wide       = LW'(len_next);
        out_start_next = start_wide[START_W-1:0];
        out_len_next   = len_wide[LENGTH_W-1:0];
        out_value_next = '0;
        if (fb_dot_next)
        begin
            out_type_next = TT_PSEUDO;
        end
        else if (fb_quote_next)
        begin
            out_type_next = TT_STRING;
        end
        else if (fb_r_next && (len_next == LEN_W'(2)) && sb_reg_next)
        begin
            out_type_next = TT_REGISTER;
        end
        else if (ok_next && dseen_next)
        begin
            out_type_next  = TT_NUMBER;
            out_value_next = acc_next;
        end
        else
        begin
            out_type_next = TT_KEYWORD;
        end

        if (take && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            in_tok_reg    <= 1'b0;
            in_str_reg    <= 1'b0;
            start_reg     <= '0;
            len_reg       <= '0;
            prev_bs_reg   <= 1'b0;
            fb_dot_reg    <= 1'b0;
            fb_quote_reg  <= 1'b0;
            fb_r_reg      <= 1'b0;
            sb_reg_reg    <= 1'b0;
            base_reg      <= BASE_10;
            stage_reg     <= 1'b0;
            neg_reg       <= 1'b0;
            ok_reg        <= 1'b0;
            dseen_reg     <= 1'b0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                pos_reg      <= pos_next;
                in_tok_reg   <= in_tok_next;
                in_str_reg   <= in_str_next;
                start_reg    <= start_next;
                len_reg      <= len_next;
                prev_bs_reg  <= prev_bs_next;
                fb_dot_reg   <= fb_dot_next;
                fb_quote_reg <= fb_quote_next;
                fb_r_reg     <= fb_r_next;
                sb_reg_reg   <= sb_reg_next;
                base_reg     <= base_next;
                stage_reg    <= stage_next;
                neg_reg      <= neg_next;
                ok_reg       <= ok_next;
                dseen_reg    <= dseen_next;
                acc_reg      <= acc_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            out_start_reg <= out_start_next;
            out_len_reg   <= out_len_next;
            out_type_reg  <= out_type_next;
            out_value_reg <= out_value_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/alt_checker.sv @@
// ----------------------------------------------------------------------------
// alt_checker
// Port-level checks of the tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module alt_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_stall,
    input wire logic [7:0]                    character,
    input wire logic                          end_of_line,
    input wire logic                          out_valid,
    input wire logic                          out_stall,
    input wire logic [alt_pkg::START_W-1:0]   token_start,
    input wire logic [alt_pkg::LENGTH_W-1:0]  token_length,
    input wire logic [alt_pkg::TYPE_W-1:0]    token_type,
    input wire logic signed [alt_pkg::VALUE_W-1:0] number_value
);
    import alt_pkg::*;

    // a stalled input word keeps its payload
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(character) && $stable(end_of_line))
        else $error("input word changed while stalled");

    // a held word keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(token_start) &&
        $stable(token_length) && $stable(token_type) && $stable(number_value))
        else $error("output word changed while stalled");

    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (token_type != TYPE_W'(TT_NUMBER)) |-> number_value == '0)
        else $error("nonzero value on a non-number token");

    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> token_length != '0)
        else $error("empty token");

    a_reg_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (token_type == TYPE_W'(TT_REGISTER)) |-> token_length == LENGTH_W'(2))
        else $error("register token not two bytes long");

endmodule

bind assembly_line_tokenizer_unit alt_checker u_alt_checker (.*);

`default_nettype wire
